### rtl/krt_pkg.sv
`timescale 1ns / 1ps

package krt_pkg;

   // Field widths of one transaction on either side.
   localparam int OP_W     = 2;
   localparam int KEY_W    = 16;
   localparam int SCORE_W  = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int SUM_W    = 16;

   // Default number of table slots.
   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Operation codes carried on the request side.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_DRAIN,
      FSM_UPDATE,
      FSM_RESULT
   } fsm_type;

   // One table slot as it sits in the memory.
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
   } entry_type;

endpackage

### rtl/keyed_record_table_with_totals_unit.sv
`timescale 1ns / 1ps

// A result is offered after the scan, drain and update states that follow acceptance of its request transaction.
// A new request is accepted only in the idle state, after the previous result has been taken;
// every operation scans all slots through the single table read port, one slot per cycle.
// Reset: synchronous; the block then clears every slot, one per cycle, with req_tready low;
// count and sum start at zero.
module keyed_record_table_with_totals_unit #(
   parameter int TABLE_DEPTH = krt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key [15:0], score [25:16], zero [31:26]
   input  logic [1:0]  req_tuser,   // op [1:0]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // found_score [9:0], entry_total [16:10],
                                    // score_total [32:17], zero [39:33]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

   // Sequencer state and slot index.
   krt_pkg::fsm_type state_ff, state_in;
   logic [AW-1:0]    idx_ff, idx_in;

   // Latched request.
   krt_pkg::op_type           op_ff;
   logic [krt_pkg::KEY_W-1:0]   key_ff;
   logic [krt_pkg::SCORE_W-1:0] score_ff;

   // Table memory with registered read.
   krt_pkg::entry_type mem [TABLE_DEPTH];
   krt_pkg::entry_type rd_data_ff;
   logic [AW-1:0]      rd_idx_ff;
   logic               cmp_pend_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   krt_pkg::entry_type wr_data;

   // Scan results.
   logic                        hit_ff;
   logic [AW-1:0]               hit_idx_ff;
   logic [krt_pkg::SCORE_W-1:0] hit_score_ff;
   logic                        free_ff;
   logic [AW-1:0]               free_idx_ff;
   logic                        key_match;

   // Totals and result registers.
   logic [krt_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [krt_pkg::SUM_W-1:0]    sum_ff, sum_in;
   krt_pkg::status_type          status_ff, status_in;
   logic [krt_pkg::SCORE_W-1:0]  fscore_ff, fscore_in;
   logic [krt_pkg::SUM_W-1:0]    addend;
   logic [krt_pkg::COUNT_W-1:0]  count_step;
   logic                         totals_change;

   // Sequencer controls.
   logic clearing;
   logic scanning;
   logic updating;
   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         krt_pkg::FSM_CLEAR: begin
            if (idx_ff == LAST_IDX) state_in = krt_pkg::FSM_IDLE;
         end
         krt_pkg::FSM_IDLE: begin
            if (req_fire) state_in = krt_pkg::FSM_SCAN;
         end
         krt_pkg::FSM_SCAN: begin
            if (idx_ff == LAST_IDX) state_in = krt_pkg::FSM_DRAIN;
         end
         krt_pkg::FSM_DRAIN: begin
            state_in = krt_pkg::FSM_UPDATE;
         end
         krt_pkg::FSM_UPDATE: begin
            state_in = krt_pkg::FSM_RESULT;
         end
         krt_pkg::FSM_RESULT: begin
            if (rsp_fire) state_in = krt_pkg::FSM_IDLE;
         end
         default: state_in = krt_pkg::FSM_CLEAR;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      clearing   = 1'b0;
      scanning   = 1'b0;
      updating   = 1'b0;
      unique case (state_ff)
         krt_pkg::FSM_CLEAR:  clearing   = 1'b1;
         krt_pkg::FSM_IDLE:   req_tready = 1'b1;
         krt_pkg::FSM_SCAN:   scanning   = 1'b1;
         krt_pkg::FSM_DRAIN:  ;
         krt_pkg::FSM_UPDATE: updating   = 1'b1;
         krt_pkg::FSM_RESULT: rsp_tvalid = 1'b1;
         default:             ;
      endcase
   end

   // Slot index walks the table during the clearing pass and during a scan.
   always_comb begin
      idx_in = idx_ff;
      if (clearing || scanning) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end
   end

   // The compare unit looks at the slot read in the previous cycle.
   assign key_match = rd_data_ff.valid && (rd_data_ff.key == key_ff);

   // Decision and totals update, with one shared adder for each total.
   always_comb begin
      status_in     = krt_pkg::ST_MISSING;
      fscore_in     = '0;
      addend        = '0;
      count_step    = '0;
      totals_change = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;
      if (clearing) begin
         wr_en = 1'b1;
      end else if (updating) begin
         priority case (op_ff)
            krt_pkg::OP_INSERT: begin
               if (hit_ff) begin
                  status_in = krt_pkg::ST_DUP;
               end else if (!free_ff) begin
                  status_in = krt_pkg::ST_FULL;
               end else begin
                  status_in     = krt_pkg::ST_OK;
                  wr_en         = 1'b1;
                  wr_addr       = free_idx_ff;
                  wr_data.valid = 1'b1;
                  wr_data.key   = key_ff;
                  wr_data.score = score_ff;
                  addend        = krt_pkg::SUM_W'(score_ff);
                  count_step    = krt_pkg::COUNT_W'(1);
                  totals_change = 1'b1;
               end
            end
            krt_pkg::OP_DELETE: begin
               if (hit_ff) begin
                  status_in     = krt_pkg::ST_OK;
                  fscore_in     = hit_score_ff;
                  wr_en         = 1'b1;
                  wr_addr       = hit_idx_ff;
                  addend        = ~krt_pkg::SUM_W'(hit_score_ff) + 1'b1;
                  count_step    = '1;
                  totals_change = 1'b1;
               end
            end
            krt_pkg::OP_SEARCH: begin
               if (hit_ff) begin
                  status_in = krt_pkg::ST_OK;
                  fscore_in = hit_score_ff;
               end
            end
            default: ;
         endcase
      end
      sum_in   = totals_change ? sum_ff + addend : sum_ff;
      count_in = totals_change ? count_ff + count_step : count_ff;
   end

   // Table memory: one write port, one registered read port at the scan index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff];
      rd_idx_ff  <= idx_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= krt_pkg::FSM_CLEAR;
         idx_ff      <= '0;
         cmp_pend_ff <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         cmp_pend_ff <= scanning;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         if (req_fire) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (cmp_pend_ff) begin
            if (key_match) hit_ff <= 1'b1;
            if (!rd_data_ff.valid) free_ff <= 1'b1;
         end
      end
   end

   // Payload registers: request fields, first hit, lowest free slot, result.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= krt_pkg::op_type'(req_tuser);
         key_ff   <= req_tdata[15:0];
         score_ff <= req_tdata[25:16];
      end
      if (cmp_pend_ff && key_match && !hit_ff) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_score_ff <= rd_data_ff.score;
      end
      if (cmp_pend_ff && !rd_data_ff.valid && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (updating) begin
         status_ff <= status_in;
         fscore_ff <= fscore_in;
      end
   end

   // Result transaction.
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {7'd0, sum_ff, count_ff, fscore_ff};

   // The block never offers a result while it can take a request.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result sides open at once");

   // An accepted request always starts a scan.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == krt_pkg::FSM_SCAN))
      else $error("accepted request did not start a scan");

   // A result appears only right after the update step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == krt_pkg::FSM_UPDATE))
      else $error("result offered without an update step");

   // The record count never exceeds the number of slots (checked for tables of up to 127 slots).
   assert property (@(posedge clock) disable iff (reset)
      (TABLE_DEPTH > 127) || (int'(count_ff) <= TABLE_DEPTH))
      else $error("record count exceeds table depth");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH       = krt_pkg::DEFAULT_TABLE_DEPTH;
   localparam int STALL_LIMIT = 3000;
   localparam int POOL_SIZE   = 96;

   // One result transaction split into its fields.
   typedef struct packed {
      krt_pkg::status_type                  status;
      logic [krt_pkg::SCORE_W-1:0]          found_score;
      logic [krt_pkg::COUNT_W-1:0]          entry_total;
      logic [krt_pkg::SUM_W-1:0]            score_total;
   } table_result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;
   logic [1:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;

   // Shadow copy of the table and its running totals.
   logic [krt_pkg::KEY_W-1:0]    shadow_key[DEPTH];
   logic [krt_pkg::SCORE_W-1:0]  shadow_score[DEPTH];
   bit                           shadow_used[DEPTH];
   logic [krt_pkg::COUNT_W-1:0]  shadow_count = '0;
   logic [krt_pkg::SUM_W-1:0]    shadow_sum   = '0;

   table_result_type             awaited_results[$];
   logic [krt_pkg::KEY_W-1:0]    key_pool[POOL_SIZE];
   bit                  steady       = 1'b0;
   int                  fail_count   = 0;
   int                  stall_cycles = 0;
   int                  request_count = 0;
   int                  status_seen[4] = '{0, 0, 0, 0};
   int                  full_drains  = 0;

   keyed_record_table_with_totals_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one operation to the shadow table and returns the result it should produce.
   function automatic table_result_type predict_table_op(krt_pkg::op_type op,
                                                         logic [krt_pkg::KEY_W-1:0] key,
                                                         logic [krt_pkg::SCORE_W-1:0] score);
      table_result_type r;
      int          hit;
      int          spare;
      r.status      = krt_pkg::ST_MISSING;
      r.found_score = '0;
      hit   = -1;
      spare = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (shadow_used[i] && shadow_key[i] == key && hit < 0) hit = i;
         if (!shadow_used[i] && spare < 0) spare = i;
      end
      case (op)
         krt_pkg::OP_INSERT: begin
            if (hit >= 0) begin
               r.status = krt_pkg::ST_DUP;
            end else if (spare < 0) begin
               r.status = krt_pkg::ST_FULL;
            end else begin
               shadow_key[spare]   = key;
               shadow_score[spare] = score;
               shadow_used[spare]  = 1'b1;
               shadow_count        = shadow_count + 1'b1;
               shadow_sum          = shadow_sum + krt_pkg::SUM_W'(score);
               r.status            = krt_pkg::ST_OK;
            end
         end
         krt_pkg::OP_DELETE: begin
            if (hit >= 0) begin
               r.found_score     = shadow_score[hit];
               shadow_used[hit]  = 1'b0;
               shadow_count      = shadow_count - 1'b1;
               shadow_sum        = shadow_sum - krt_pkg::SUM_W'(shadow_score[hit]);
               r.status          = krt_pkg::ST_OK;
            end
         end
         krt_pkg::OP_SEARCH: begin
            if (hit >= 0) begin
               r.found_score = shadow_score[hit];
               r.status      = krt_pkg::ST_OK;
            end
         end
         default: begin
         end
      endcase
      r.entry_total = shadow_count;
      r.score_total = shadow_sum;
      return r;
   endfunction

   // Offers one request transaction and records its expected result once it is taken.
   task automatic send_request(krt_pkg::op_type op, logic [krt_pkg::KEY_W-1:0] key,
                               logic [krt_pkg::SCORE_W-1:0] score);
      if (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 70)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, score, key};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      awaited_results.push_back(predict_table_op(op, key, score));
      request_count++;
   endtask

   // Holds the request side idle until every outstanding result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      full_drains++;
   endtask

   // Empty-table lookups, key and score extremes, duplicates and the unused op code.
   task automatic test_directed_cases();
      send_request(krt_pkg::OP_SEARCH, 16'h0000, 10'h000);
      send_request(krt_pkg::OP_DELETE, 16'h1234, 10'h3FF);
      send_request(krt_pkg::OP_NOP,    16'hFFFF, 10'h3FF);
      send_request(krt_pkg::OP_INSERT, 16'h0000, 10'h000);
      send_request(krt_pkg::OP_INSERT, 16'hFFFF, 10'h3FF);
      send_request(krt_pkg::OP_INSERT, 16'hFFFF, 10'h001);
      send_request(krt_pkg::OP_SEARCH, 16'hFFFF, 10'h000);
      send_request(krt_pkg::OP_SEARCH, 16'h0000, 10'h3FF);
      send_request(krt_pkg::OP_INSERT, 16'h5A5A, 10'h2AA);
      send_request(krt_pkg::OP_INSERT, 16'hA5A5, 10'h155);
      send_request(krt_pkg::OP_NOP,    16'hA5A5, 10'h3FF);
      send_request(krt_pkg::OP_SEARCH, 16'hA5A5, 10'h000);
      send_request(krt_pkg::OP_DELETE, 16'h0000, 10'h000);
      send_request(krt_pkg::OP_DELETE, 16'h0000, 10'h000);
      send_request(krt_pkg::OP_SEARCH, 16'h0000, 10'h000);
      send_request(krt_pkg::OP_DELETE, 16'hFFFF, 10'h000);
      send_request(krt_pkg::OP_DELETE, 16'h5A5A, 10'h000);
      send_request(krt_pkg::OP_DELETE, 16'hA5A5, 10'h000);
      send_request(krt_pkg::OP_SEARCH, 16'hFFFF, 10'h000);
      wait_for_results();
   endtask

   // Fills every slot at the top score, probes the full table, then empties it again.
   task automatic test_fill_to_capacity();
      logic [krt_pkg::KEY_W-1:0] base;
      base = krt_pkg::KEY_W'($urandom_range(0, 65535));
      for (int i = 0; i < DEPTH; i++) begin
         send_request(krt_pkg::OP_INSERT, base + krt_pkg::KEY_W'(i * 977), 10'h3FF);
      end
      send_request(krt_pkg::OP_INSERT, base + krt_pkg::KEY_W'(DEPTH * 977), 10'h001);
      send_request(krt_pkg::OP_INSERT, base, 10'h002);
      send_request(krt_pkg::OP_SEARCH, base + krt_pkg::KEY_W'((DEPTH - 1) * 977), 10'h000);
      for (int i = DEPTH - 1; i >= 0; i--) begin
         send_request(krt_pkg::OP_DELETE, base + krt_pkg::KEY_W'(i * 977), 10'h000);
      end
      wait_for_results();
   endtask

   // Mixed traffic over a small key pool, alternating between filling and draining phases.
   task automatic test_random_traffic(int count);
      int                          pick;
      bit                          filling;
      krt_pkg::op_type             op;
      logic [krt_pkg::KEY_W-1:0]   key;
      logic [krt_pkg::SCORE_W-1:0] score;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = krt_pkg::KEY_W'($urandom_range(0, 65535));
      end
      for (int n = 0; n < count; n++) begin
         filling = ((n / 150) % 2) == 0;
         steady  = (n >= 400 && n < 650);
         if (n == 700) wait_for_results();
         pick = $urandom_range(99);
         if (pick < (filling ? 60 : 25)) op = krt_pkg::OP_INSERT;
         else if (pick < (filling ? 75 : 70)) op = krt_pkg::OP_DELETE;
         else if (pick < 95) op = krt_pkg::OP_SEARCH;
         else op = krt_pkg::OP_NOP;
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else key = krt_pkg::KEY_W'($urandom_range(0, 65535));
         if ($urandom_range(99) < 10) score = $urandom_range(1) ? 10'h3FF : 10'h000;
         else score = krt_pkg::SCORE_W'($urandom_range(0, 1023));
         send_request(op, key, score);
      end
      steady = 1'b0;
   endtask

   // Result side: random back-pressure, except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 24);
   end

   // Compares every result transaction with the oldest expectation.
   always @(posedge clock) begin
      table_result_type want;
      table_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = krt_pkg::status_type'(rsp_tuser);
         got.found_score = rsp_tdata[9:0];
         got.entry_total = rsp_tdata[16:10];
         got.score_total = rsp_tdata[32:17];
         if (awaited_results.size() == 0) begin
            $error("result with no request outstanding: status %0d", got.status);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               fail_count++;
            end
            if (got.found_score !== want.found_score) begin
               $error("found_score: expected %0d, got %0d", want.found_score, got.found_score);
               fail_count++;
            end
            if (got.entry_total !== want.entry_total) begin
               $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
               fail_count++;
            end
            if (got.score_total !== want.score_total) begin
               $error("score_total: expected %0d, got %0d", want.score_total, got.score_total);
               fail_count++;
            end
         end
      end
   end

   // Ends the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("keyed_record_table_with_totals_unit verification failed");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_fill_to_capacity();
      test_random_traffic(1250);
      wait_for_results();
      repeat (DEPTH + 10) @(posedge clock);
      $display("Ran %0d requests with %0d full drains.", request_count, full_drains);
      $display("Results by status: ok %0d, duplicate %0d, not found %0d, table full %0d.",
               status_seen[krt_pkg::ST_OK], status_seen[krt_pkg::ST_DUP],
               status_seen[krt_pkg::ST_MISSING], status_seen[krt_pkg::ST_FULL]);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("keyed_record_table_with_totals_unit verification clean");
      end else begin
         $display("keyed_record_table_with_totals_unit verification failed");
      end
      $finish;
   end

endmodule
